// ===== src/bb3_pkg.sv =====
// Shared types, constants and arithmetic helpers for the 3x3 RGB box blur.
// Depends on nothing; every other file of the block imports it.
package bb3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int FW_W      = 11;
    localparam int CH_W      = 8;
    localparam int SUM_W     = 12;
    localparam int N_W       = 4;
    localparam int RECIP_W   = 20;
    localparam int X_W       = SUM_W + 1;
    localparam int PROD_W    = X_W + RECIP_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    // Channel 0 is red, 1 green, 2 blue.
    typedef logic [2:0][CH_W-1:0] px_t;
    // Row 0 is two rows up, row 1 the row above, row 2 the current row.
    typedef px_t [2:0] col_t;

    typedef struct packed {
        px_t prev;
        px_t older;
    } line_t;

    typedef struct packed {
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col;
        logic [2:0][SUM_W-1:0]     sum;
        logic [N_W-1:0]            n;
    } res_t;

    // Sum of one channel over rows r0..2 of the newest 'ages' columns.
    function automatic logic [SUM_W-1:0] win_sum(col_t c0, col_t c1, col_t c2,
                                                 logic [1:0] r0, logic [1:0] ages,
                                                 logic [1:0] ch);
        logic [SUM_W-1:0] s;
        s = '0;
        for (int r = 0; r < 3; r++) begin
            if (2'(r) >= r0) begin
                s = s + SUM_W'(c0[r][ch]);
                if (ages >= 2'd2) s = s + SUM_W'(c1[r][ch]);
                if (ages == 2'd3) s = s + SUM_W'(c2[r][ch]);
            end
        end
        return s;
    endfunction

    function automatic logic [N_W-1:0] n_count(logic [1:0] r0, logic [1:0] ages);
        logic [N_W-1:0] rows;
        rows = N_W'(2'd3 - r0);
        return N_W'(rows * N_W'(ages));
    endfunction

    // ceil(2^20 / (2n)); exact floor division for numerators below 2^13.
    function automatic logic [RECIP_W-1:0] recip(logic [N_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd6:    m = 20'd87382;
            4'd9:    m = 20'd58255;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== src/bb3_if.sv =====
// Stream interfaces for the box blur: input pixel words and result words.
// Depends on bb3_pkg for the field widths.
interface bb_pix_if import bb3_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;

    modport source (output valid, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface bb_res_if import bb3_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_column;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic             run_last;

    modport source (output valid, out_row, out_column, out_red, out_green, out_blue,
                    run_last, input ready);
    modport sink   (input valid, out_row, out_column, out_red, out_green, out_blue,
                    run_last, output ready);
endinterface

// ===== src/bb3_line_mem.sv =====
// Line buffer memory: one entry per column holding the two previous rows.
// Depends on bb3_pkg; one read and one write port, registered read data.
module bb3_line_mem import bb3_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    output line_t            rd_data,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  line_t            wr_data
);

    line_t mem [MAX_WIDTH];
    line_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/bb3_mean.sv =====
// Rounded mean unit and output register: divides the three channel sums by
// the neighbour count through reciprocal multiplication. Depends on bb3_pkg, bb3_if.
module bb3_mean import bb3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  res_t        cand,
    input  logic        last,
    output logic        free,
    bb_res_if.source    res_out
);

    logic [2:0][X_W-1:0]    x;
    logic [2:0][PROD_W-1:0] prod;
    logic [RECIP_W-1:0]     m;

    logic             valid_reg, valid_next;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    px_t              px_reg;
    logic             last_reg;

    // floor((2*sum + n) / (2*n)) as (2*sum + n) * ceil(2^20/(2n)) >> 20.
    always_comb
    begin
        m = recip(cand.n);
        for (int ch = 0; ch < 3; ch++)
        begin
            x[ch]    = X_W'({cand.sum[ch], 1'b0}) + X_W'(cand.n);
            prod[ch] = PROD_W'(x[ch]) * PROD_W'(m);
        end
    end

    assign free = !valid_reg || res_out.ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (res_out.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg  <= cand.row;
            col_reg  <= cand.col;
            last_reg <= last;
            for (int ch = 0; ch < 3; ch++)
            begin
                px_reg[ch] <= prod[ch][RECIP_W+CH_W-1:RECIP_W];
            end
        end
    end

    assign res_out.valid      = valid_reg;
    assign res_out.out_row    = row_reg;
    assign res_out.out_column = col_reg;
    assign res_out.out_red    = px_reg[0];
    assign res_out.out_green  = px_reg[1];
    assign res_out.out_blue   = px_reg[2];
    assign res_out.run_last   = last_reg;

endmodule

// ===== src/box_blur_3x3_rgb.sv =====
// Top level of the streaming 3x3 RGB box blur.
// Depends on bb3_pkg, bb3_if, bb3_line_mem and bb3_mean.
//
// Pixels enter on pix_in in raster order; results leave on res_out tagged
// with row and column. Each result is the per-channel mean of the in-frame
// pixels of its 3x3 neighbourhood, rounded half up. A result for row i-1
// leaves once row i has reached the column to its right; the last row's
// results follow those of the row above, word by word.
// An input word passes the line buffer read, then the window update and write
// back in the calc state; the emit state then loads each result it releases,
// in turn, into the output register, and no new pixel is taken until the last
// has been loaded. A result passes the candidate register and then the output
// register before it is on res_out.
// Writing frame_width or frame_height restarts the frame at row 0, column 0.
// Reset loads a 640 x 480 frame and restarts; the line buffers need no clear.
// A stalled receiver holds the output register; the block then waits
// before releasing further results and stops accepting pixels.
module box_blur_3x3_rgb import bb3_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    bb_pix_if.sink               pix_in,
    bb_res_if.source             res_out
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [FW_W-1:0]  fw_reg, fw_next;
    logic [ROW_W-1:0] fh_reg, fh_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    col_t [2:0]       win_reg, win_next;
    logic [3:0]       pend_reg, pend_next;
    res_t [3:0]       res_reg, res_next;
    px_t              px_reg;

    logic             accept;
    line_t            rd_data;
    line_t            wr_data;
    logic             wr_en;
    col_t             c0;
    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;
    logic             row_ge1, row_ge2, col_ge1, col_ge2, col_last, row_last;
    logic [1:0]       r0a, r0c, ages_a, ages_b;
    res_t [3:0]       cand;
    logic [1:0]       sel;
    logic [3:0]       rest;
    logic             free;
    logic             load;

    assign accept       = pix_in.valid && pix_in.ready;
    assign pix_in.ready = (state_reg == S_IDLE);

    bb3_line_mem u_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (col_reg),
        .wr_data (wr_data)
    );

    // Effective frame limits: zero counts as one, width saturates.
    always_comb
    begin
        if (fw_reg == '0)
            w_last = '0;
        else if (fw_reg > FW_W'(MAX_WIDTH))
            w_last = COL_W'(MAX_WIDTH - 1);
        else
            w_last = COL_W'(fw_reg - 1'b1);
        h_last = (fh_reg == '0) ? '0 : fh_reg - 1'b1;
    end

    always_comb
    begin
        row_ge1  = (row_reg != '0);
        row_ge2  = (row_reg >= ROW_W'(2));
        col_ge1  = (col_reg != '0);
        col_ge2  = (col_reg >= COL_W'(2));
        col_last = (col_reg == w_last);
        row_last = (row_reg == h_last);
        r0a      = row_ge2 ? 2'd0 : 2'd1;
        r0c      = row_ge1 ? 2'd1 : 2'd2;
        ages_a   = col_ge2 ? 2'd3 : 2'd2;
        ages_b   = col_ge1 ? 2'd2 : 2'd1;

        c0[0] = rd_data.older;
        c0[1] = rd_data.prev;
        c0[2] = px_reg;
        wr_data.prev  = px_reg;
        wr_data.older = rd_data.prev;

        cand[0].row = row_reg - 1'b1;
        cand[0].col = col_reg - 1'b1;
        cand[0].n   = n_count(r0a, ages_a);
        cand[1].row = row_reg - 1'b1;
        cand[1].col = col_reg;
        cand[1].n   = n_count(r0a, ages_b);
        cand[2].row = row_reg;
        cand[2].col = col_reg - 1'b1;
        cand[2].n   = n_count(r0c, ages_a);
        cand[3].row = row_reg;
        cand[3].col = col_reg;
        cand[3].n   = n_count(r0c, ages_b);
        for (int ch = 0; ch < 3; ch++)
        begin
            cand[0].sum[ch] = win_sum(c0, win_reg[0], win_reg[1], r0a, ages_a, 2'(ch));
            cand[1].sum[ch] = win_sum(c0, win_reg[0], win_reg[1], r0a, ages_b, 2'(ch));
            cand[2].sum[ch] = win_sum(c0, win_reg[0], win_reg[1], r0c, ages_a, 2'(ch));
            cand[3].sum[ch] = win_sum(c0, win_reg[0], win_reg[1], r0c, ages_b, 2'(ch));
        end
    end

    // Lowest pending result goes first: row above before last row.
    always_comb
    begin
        sel = 2'd0;
        for (int k = 3; k >= 0; k--)
        begin
            if (pend_reg[k]) sel = 2'(k);
        end
        rest = pend_reg & ~(4'b0001 << sel);
    end

    assign load = (state_reg == S_EMIT) && free;

    bb3_mean u_mean (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .cand    (res_reg[sel]),
        .last    (rest == '0),
        .free    (free),
        .res_out (res_out)
    );

    always_comb
    begin
        state_next = state_reg;
        fw_next    = fw_reg;
        fh_next    = fh_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        win_next   = win_reg;
        pend_next  = pend_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_CALC;
            end
            S_CALC:
            begin
                wr_en     = 1'b1;
                win_next  = {win_reg[1], win_reg[0], c0};
                res_next  = cand;
                pend_next = {row_last && col_last, row_last && col_ge1,
                             row_ge1 && col_last, row_ge1 && col_ge1};
                if (col_last)
                begin
                    col_next = '0;
                    row_next = row_last ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
                state_next = (pend_next == '0) ? S_IDLE : S_EMIT;
            end
            S_EMIT:
            begin
                if (free)
                begin
                    pend_next = rest;
                    if (rest == '0)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  fw_next = cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: fh_next = cfg_data[ROW_W-1:0];
                default:          fw_next = fw_reg;
            endcase
            col_next = '0;
            row_next = '0;
            win_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fw_reg    <= FRAME_WIDTH_RST;
            fh_reg    <= FRAME_HEIGHT_RST;
            col_reg   <= '0;
            row_reg   <= '0;
            win_reg   <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fw_reg    <= fw_next;
            fh_reg    <= fh_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            win_reg   <= win_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            px_reg <= {pix_in.in_blue, pix_in.in_green, pix_in.in_red};
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the streaming 3x3 RGB box blur (box_blur_3x3_rgb).
// Depends on bb3_pkg, bb3_if and the block; a scripted frame set is followed by random frames.
module testbench;
    import bb3_pkg::*;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        px_t              mean;
        logic             last;
    } blur_word_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] data;
        px_t                  pix;
        bit                   solo;   // 1x1 frame: the word must come back unchanged
    } script_row_t;

    localparam int SCRIPT_LEN = 28;
    localparam int SETTLE     = 10;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    bb_pix_if pix ();
    bb_res_if res ();

    box_blur_3x3_rgb dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix),
        .res_out   (res)
    );

    always #6 clk = ~clk;

    // Blur predictor state.
    logic [FW_W-1:0]  width_reg;
    logic [ROW_W-1:0] height_reg;
    px_t              line_prev  [MAX_WIDTH];
    px_t              line_older [MAX_WIDTH];
    int unsigned      col_pos;
    int unsigned      row_pos;
    px_t              win [3][3];   // [age][row], row 2 is the current row
    blur_word_t       fresh [$];
    blur_word_t       pending_q [$];

    int unsigned pixels_sent  = 0;
    int unsigned words_seen   = 0;
    int unsigned settings     = 0;
    int unsigned fails        = 0;
    int unsigned hold_left    = 0;
    bit          squeezed     = 1'b0;

    script_row_t script [0:SCRIPT_LEN-1] = '{
        '{1'b1, REG_FRAME_WIDTH,  16'd1, 24'h0, 1'b0},
        '{1'b1, REG_FRAME_HEIGHT, 16'd1, 24'h0, 1'b0},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'h000000, 1'b1},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'hFFFFFF, 1'b1},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'h0FAA55, 1'b1},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'hF055AA, 1'b1},
        '{1'b1, REG_FRAME_WIDTH,  16'd0, 24'h0, 1'b0},
        '{1'b1, REG_FRAME_HEIGHT, 16'd0, 24'h0, 1'b0},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'h030201, 1'b1},
        '{1'b1, REG_FRAME_WIDTH,  16'd3, 24'h0, 1'b0},
        '{1'b1, REG_FRAME_HEIGHT, 16'd3, 24'h0, 1'b0},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'hFFFFFF, 1'b0},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'h000000, 1'b0},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'hFFFFFF, 1'b0},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'h000000, 1'b0},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'hFFFFFF, 1'b0},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'h000000, 1'b0},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'hFFFFFF, 1'b0},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'h010101, 1'b0},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'hFEFEFE, 1'b0},
        '{1'b1, REG_FRAME_WIDTH,  16'd2, 24'h0, 1'b0},
        '{1'b1, REG_FRAME_HEIGHT, 16'hFFFF, 24'h0, 1'b0},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'h123456, 1'b0},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'hFF00FF, 1'b0},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'h00FF00, 1'b0},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'h808080, 1'b0},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'h7F7F7F, 1'b0},
        '{1'b0, REG_FRAME_WIDTH,  16'd0, 24'hABCDEF, 1'b0}
    };

    function automatic void frame_restart();
        col_pos = 0;
        row_pos = 0;
        foreach (win[a, r])
            win[a][r] = '0;
    endfunction

    function automatic void model_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
        if (idx == REG_FRAME_WIDTH)
            width_reg = d[FW_W-1:0];
        else
            height_reg = d[ROW_W-1:0];
        frame_restart();
    endfunction

    // Rounded mean over rows r0..2 of the newest oldest+1 window columns.
    function automatic void emit_mean(int unsigned row, int unsigned col, int r0, int oldest);
        blur_word_t  w;
        int unsigned sum;
        int unsigned n;
        n = (3 - r0) * (oldest + 1);
        w.row = row[ROW_W-1:0];
        w.col = col[COL_W-1:0];
        w.last = 1'b0;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum = 0;
            for (int a = 0; a <= oldest; a++)
                for (int r = r0; r < 3; r++)
                    sum += win[a][r][ch];
            w.mean[ch] = 8'((2 * sum + n) / (2 * n));
        end
        fresh.push_back(w);
    endfunction

    function automatic void blur_pixel(px_t p);
        int unsigned w;
        int unsigned h;
        int unsigned i;
        int unsigned j;
        int          r0;
        w = width_reg;
        h = height_reg;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h == 0) h = 1;
        if (col_pos >= w || row_pos >= h) frame_restart();
        i = row_pos;
        j = col_pos;
        win[2] = win[1];
        win[1] = win[0];
        win[0][0] = line_older[j];
        win[0][1] = line_prev[j];
        win[0][2] = p;
        line_older[j] = line_prev[j];
        line_prev[j] = p;
        fresh.delete();
        // The row above completes once this row has reached the column to its right.
        if (i >= 1)
        begin
            r0 = (i >= 2) ? 0 : 1;
            if (j >= 1) emit_mean(i - 1, j - 1, r0, (j >= 2) ? 2 : 1);
            if (j == w - 1) emit_mean(i - 1, j, r0, (j >= 1) ? 1 : 0);
        end
        if (i == h - 1)
        begin
            r0 = (i >= 1) ? 1 : 2;
            if (j >= 1) emit_mean(i, j - 1, r0, (j >= 2) ? 2 : 1);
            if (j == w - 1) emit_mean(i, j, r0, (j >= 1) ? 1 : 0);
        end
        if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
        if (j == w - 1)
        begin
            col_pos = 0;
            row_pos = (i == h - 1) ? 0 : i + 1;
        end
        else
            col_pos = j + 1;
    endfunction

    task automatic send_pixel(px_t p, bit solo);
        blur_word_t want;
        bit         calm;
        calm = (pixels_sent >= 60 && pixels_sent < 100);
        while (!calm && $urandom_range(99) < 34)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.in_red <= p[0];
        pix.in_green <= p[1];
        pix.in_blue <= p[2];
        @(posedge clk);
        while (!pix.ready) @(posedge clk);
        pixels_sent++;
        blur_pixel(p);
        if (solo)
        begin
            want.row = '0;
            want.col = '0;
            want.mean = p;
            want.last = 1'b1;
            pending_q.push_back(want);
        end
        else
            foreach (fresh[k]) pending_q.push_back(fresh[k]);
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0) @(posedge clk);
    endtask

    // A word without results may still be in flight, so let the pipeline empty too.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
        pix.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_reg_write(idx, d);
    endtask

    task automatic set_frame(logic [CFG_DAT_W-1:0] wd, logic [CFG_DAT_W-1:0] hd);
        settings++;
        if ($urandom_range(1))
        begin
            write_reg(REG_FRAME_HEIGHT, hd);
            write_reg(REG_FRAME_WIDTH, wd);
        end
        else
        begin
            write_reg(REG_FRAME_WIDTH, wd);
            write_reg(REG_FRAME_HEIGHT, hd);
        end
    endtask

    task automatic check_word();
        blur_word_t e;
        if (pending_q.size() == 0)
        begin
            $error("unexpected result word at row %0d column %0d", res.out_row, res.out_column);
            fails++;
        end
        else
        begin
            e = pending_q.pop_front();
            if (res.out_row !== e.row)
            begin
                $error("out_row: expected %0d, got %0d", e.row, res.out_row);
                fails++;
            end
            if (res.out_column !== e.col)
            begin
                $error("out_column: expected %0d, got %0d", e.col, res.out_column);
                fails++;
            end
            if (res.out_red !== e.mean[0])
            begin
                $error("out_red: expected %0d, got %0d", e.mean[0], res.out_red);
                fails++;
            end
            if (res.out_green !== e.mean[1])
            begin
                $error("out_green: expected %0d, got %0d", e.mean[1], res.out_green);
                fails++;
            end
            if (res.out_blue !== e.mean[2])
            begin
                $error("out_blue: expected %0d, got %0d", e.mean[2], res.out_blue);
                fails++;
            end
            if (res.run_last !== e.last)
            begin
                $error("run_last: expected %0d, got %0d", e.last, res.run_last);
                fails++;
            end
        end
        words_seen++;
    endtask

    // Receiver: random back-pressure, one long hold-off to fill the block, and a calm stretch.
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready) check_word();
        if (!squeezed && words_seen >= 60 && pix.valid)
        begin
            squeezed = 1'b1;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res.ready <= 1'b0;
        end
        else if (words_seen >= 80 && words_seen < 130)
            res.ready <= 1'b1;
        else
            res.ready <= ($urandom_range(99) >= 34);
    end

    initial
    begin
        #5000000;
        $display("box_blur_3x3_rgb test failed");
        $finish;
    end

    initial
    begin
        int unsigned      rand_items;
        int unsigned      phase;
        int unsigned      w;
        int unsigned      h;
        int unsigned      count;
        logic [CFG_DAT_W-1:0] wd;
        logic [CFG_DAT_W-1:0] hd;
        rand_items = 0;
        phase = 0;
        pix.valid = 1'b0;
        pix.in_red = '0;
        pix.in_green = '0;
        pix.in_blue = '0;
        res.ready = 1'b0;
        width_reg = FRAME_WIDTH_RST;
        height_reg = FRAME_HEIGHT_RST;
        frame_restart();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[k])
        begin
            if (script[k].is_cfg)
            begin
                settings++;
                write_reg(script[k].idx, script[k].data);
            end
            else
                send_pixel(script[k].pix, script[k].solo);
        end

        while (phase <= 3 || rand_items < 90)
        begin
            if (phase == 3)
            begin
                // Widest line: the width saturates; the start of a single-row frame is sent.
                set_frame(16'hFFFF, 16'd1);
                for (int k = 0; k < 16; k++)
                    send_pixel(px_t'($urandom), 1'b0);
            end
            else
            begin
                w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
                h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
                wd = CFG_DAT_W'(w);
                hd = CFG_DAT_W'(h);
                // Bits above the width field are ignored by the block.
                if ($urandom_range(3) == 0) wd[CFG_DAT_W-1:FW_W] = 5'($urandom);
                set_frame(wd, hd);
                if (w == 0) w = 1;
                if (h == 0) h = 1;
                if ($urandom_range(4) == 0)
                    count = $urandom_range(1, w * h);
                else
                    count = w * h * $urandom_range(1, 2);
                for (int k = 0; k < count; k++)
                    send_pixel(px_t'($urandom), 1'b0);
                rand_items += count;
            end
            phase++;
        end
        pix.valid <= 1'b0;

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (pending_q.size() != 0)
        begin
            $error("%0d result words never arrived", pending_q.size());
            fails++;
        end
        $display("Run covered %0d pixel words, %0d result words and %0d frame settings.",
                 pixels_sent, words_seen, settings);
        if (fails == 0)
            $display("box_blur_3x3_rgb test passed");
        else
            $display("box_blur_3x3_rgb test failed");
        $finish;
    end

endmodule
